// ----- hw/rtl/pcba_pkg.sv -----
package pcba_pkg;

	// command codes
	localparam logic [2:0] CMD_CHECK   = 3'd0;
	localparam logic [2:0] CMD_RESERVE = 3'd1;
	localparam logic [2:0] CMD_RELEASE = 3'd2;
	localparam logic [2:0] CMD_QUERY   = 3'd3;
	localparam logic [2:0] CMD_CLEAR   = 3'd4;

	localparam int unsigned NUM_CLASSES = 4;
	localparam int unsigned RATE_W      = 32;
	localparam int unsigned PCT_W       = 8;

	// product of counter and percent scale fits in 39 bits
	localparam int unsigned PROD_W = 39;
	localparam int unsigned DIVR_W = RATE_W + PCT_W;

	// quotient steps: one overflow step, then eight quotient bits
	localparam int unsigned DIV_STEPS = PCT_W + 1;
	localparam logic [3:0]  DIV_LAST  = 4'(DIV_STEPS - 1);

	localparam logic [PROD_W-1:0] PCT_SCALE = PROD_W'(100);
	localparam logic [PCT_W-1:0]  PCT_MAX   = 8'd255;

	localparam logic [RATE_W-1:0] LIMIT_RST_RT = 32'd400000000;
	localparam logic [RATE_W-1:0] LIMIT_RST_ST = 32'd300000000;
	localparam logic [RATE_W-1:0] LIMIT_RST_CT = 32'd150000000;
	localparam logic [RATE_W-1:0] LIMIT_RST_BE = 32'd150000000;

	// stream packing
	localparam int unsigned IN_TDATA_W  = 40;
	localparam int unsigned OUT_TDATA_W = 48;

	typedef struct packed {
		logic load_in;    // capture input transaction
		logic exec;       // apply command, stage result, seed divider
		logic div_step;   // one restoring division step
		logic div_first;  // step that tests for overflow
		logic out_load;   // move staged result into output register
	} pcba_cmd_t;

	typedef struct packed {
		logic is_div;     // latched item is a query on a valid class
	} pcba_sts_t;

endpackage

// ----- hw/rtl/per_class_bandwidth_admission_core.sv -----
// per-class bandwidth admission: four 32-bit reserved-rate counters, one per
// traffic class, each checked against a configurable limit. every input
// transaction carries one command (check, reserve, release, query, clear) and
// yields exactly one output transaction. a query on a valid class also runs
// the restoring divider that forms usage*100/limit one quotient bit per cycle
// (one overflow step plus eight bits). one item is processed at a time; the
// output register lets a new input be accepted while the previous result
// waits. the user must write limits through the cfg port (index 0..3)
// only while the block is idle; the block itself does not enforce this.
module per_class_bandwidth_admission_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream: [2:0] command, [5:3] traffic_class, [37:6] flow_rate
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	// output stream: [0] accepted, [8:1] usage_percent, [40:9] class_usage
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,
	// limit register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	pcba_pkg::pcba_cmd_t cmd;
	pcba_pkg::pcba_sts_t sts;

	// limit writes are always taken
	assign cfg_ready = 1'b1;

	// sequencing: capture, execute, divide, hand off
	pcba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// counters, limits, arithmetic and output register
	pcba_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- hw/rtl/pcba_ctrl.sv -----
module pcba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  pcba_pkg::pcba_sts_t sts,
	output pcba_pkg::pcba_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t     state_q;
	logic [3:0] step_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign cmd.load_in   = in_valid && (state_q == ST_IDLE);
	assign cmd.exec      = (state_q == ST_EXEC);
	assign cmd.div_step  = (state_q == ST_DIV);
	assign cmd.div_first = (step_q == 4'd0);
	assign cmd.out_load  = (state_q == ST_DONE) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					step_q  <= 4'd0;
					state_q <= sts.is_div ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == pcba_pkg::DIV_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/pcba_dp.sv -----
module pcba_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [pcba_pkg::IN_TDATA_W-1:0]      in_data,
	output logic [pcba_pkg::OUT_TDATA_W-1:0]     out_data,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [pcba_pkg::RATE_W-1:0]          cfg_data,
	input  pcba_pkg::pcba_cmd_t                  cmd,
	output pcba_pkg::pcba_sts_t                  sts
);

	logic [pcba_pkg::RATE_W-1:0] rate_q  [pcba_pkg::NUM_CLASSES];
	logic [pcba_pkg::RATE_W-1:0] limit_q [pcba_pkg::NUM_CLASSES];

	// latched transaction
	logic [2:0]                  opc_q;
	logic [2:0]                  cls_q;
	logic [pcba_pkg::RATE_W-1:0] flow_q;

	// staged result
	logic                        acc_q;
	logic [pcba_pkg::RATE_W-1:0] use_q;

	// divider
	logic [pcba_pkg::PROD_W-1:0] rem_q;
	logic [pcba_pkg::DIVR_W-1:0] divr_q;
	logic [pcba_pkg::PCT_W-1:0]  quo_q;
	logic                        sat_q;
	logic                        qry_q;

	logic [pcba_pkg::OUT_TDATA_W-1:0] out_q;

	logic                        cls_ok;
	logic [1:0]                  idx;
	logic [pcba_pkg::RATE_W-1:0] cur;
	logic [pcba_pkg::RATE_W-1:0] lim;
	logic [pcba_pkg::RATE_W:0]   sum;
	logic                        fits;
	logic [pcba_pkg::RATE_W-1:0] rsv_val;
	logic [pcba_pkg::RATE_W-1:0] rel_val;
	logic                        res_acc;
	logic [pcba_pkg::RATE_W-1:0] res_use;
	logic [pcba_pkg::PROD_W-1:0] prod;
	logic                        ge;
	logic [pcba_pkg::PCT_W-1:0]  pct;

	assign cls_ok = ~cls_q[2];
	assign idx    = cls_q[1:0];
	assign cur    = rate_q[idx];
	assign lim    = limit_q[idx];
	assign sts.is_div = cls_ok && (opc_q == pcba_pkg::CMD_QUERY);

	assign sum     = {1'b0, cur} + {1'b0, flow_q};
	assign fits    = (sum <= {1'b0, lim});
	assign rsv_val = sum[pcba_pkg::RATE_W] ? '1 : sum[pcba_pkg::RATE_W-1:0];
	assign rel_val = (cur >= flow_q) ? (cur - flow_q) : '0;
	assign prod    = pcba_pkg::PROD_W'(cur) * pcba_pkg::PCT_SCALE;
	assign ge      = ({1'b0, rem_q} >= divr_q);
	assign pct     = !qry_q ? '0 : (sat_q ? pcba_pkg::PCT_MAX : quo_q);
	assign out_data = out_q;

	always_comb begin
		res_acc = 1'b0;
		res_use = '0;
		if (cls_ok) begin
			res_use = cur;
			unique case (opc_q)
				pcba_pkg::CMD_CHECK:   res_acc = fits;
				pcba_pkg::CMD_RESERVE: begin
					res_acc = 1'b1;
					res_use = rsv_val;
				end
				pcba_pkg::CMD_RELEASE: begin
					res_acc = 1'b1;
					res_use = rel_val;
				end
				pcba_pkg::CMD_QUERY:   res_acc = 1'b1;
				pcba_pkg::CMD_CLEAR: begin
					res_acc = 1'b1;
					res_use = '0;
				end
				default:               res_acc = 1'b0;
			endcase
		end
	end

	// counters and limits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcba_pkg::NUM_CLASSES; i++) begin
				rate_q[i] <= '0;
			end
			limit_q[0] <= pcba_pkg::LIMIT_RST_RT;
			limit_q[1] <= pcba_pkg::LIMIT_RST_ST;
			limit_q[2] <= pcba_pkg::LIMIT_RST_CT;
			limit_q[3] <= pcba_pkg::LIMIT_RST_BE;
		end else begin
			if (cfg_we) begin
				limit_q[cfg_index] <= cfg_data;
			end
			if (cmd.exec && cls_ok) begin
				unique case (opc_q)
					pcba_pkg::CMD_RESERVE: rate_q[idx] <= rsv_val;
					pcba_pkg::CMD_RELEASE: rate_q[idx] <= rel_val;
					pcba_pkg::CMD_CLEAR: begin
						for (int i = 0; i < pcba_pkg::NUM_CLASSES; i++) begin
							rate_q[i] <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			opc_q  <= in_data[2:0];
			cls_q  <= in_data[5:3];
			flow_q <= in_data[37:6];
		end
		if (cmd.exec) begin
			acc_q  <= res_acc;
			use_q  <= res_use;
			qry_q  <= sts.is_div;
			rem_q  <= prod;
			divr_q <= {lim, {pcba_pkg::PCT_W{1'b0}}};
			quo_q  <= '0;
			sat_q  <= 1'b0;
		end
		if (cmd.div_step) begin
			if (ge) begin
				rem_q <= pcba_pkg::PROD_W'({1'b0, rem_q} - divr_q);
			end
			if (cmd.div_first) begin
				sat_q <= ge;
			end else begin
				quo_q <= {quo_q[pcba_pkg::PCT_W-2:0], ge};
			end
			divr_q <= divr_q >> 1;
		end
		if (cmd.out_load) begin
			out_q <= {7'd0, use_q, pct, acc_q};
		end
	end

endmodule

// ----- dv/admission_checker.sv -----
`timescale 1ns / 100ps

module admission_checker
	import pcba_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [RATE_W-1:0]      cfg_data,
	output int                     errors,
	output int                     pending
);

	localparam int REPORT_MAX = 10;
	localparam int CLS_LSB    = 3;
	localparam int RATE_LSB   = 6;
	localparam int USAGE_LSB  = PCT_W + 1;

	typedef struct packed {
		logic              accepted;
		logic [PCT_W-1:0]  percent;
		logic [RATE_W-1:0] usage;
	} verdict_t;

	logic [RATE_W-1:0] limit_q    [NUM_CLASSES];
	logic [RATE_W-1:0] reserved_q [NUM_CLASSES];
	verdict_t          expected_verdicts [$];
	verdict_t          got;
	verdict_t          want;
	int                mismatches;

	// applies one command to the reserved-rate counters, returns the verdict
	function automatic verdict_t admit(input logic [2:0] cmd, input logic [2:0] cls,
		input logic [RATE_W-1:0] rate);
		verdict_t          v;
		logic [RATE_W:0]   sum;
		logic [63:0]       scaled;
		logic [RATE_W-1:0] cur;
		logic [RATE_W-1:0] lim;
		v = '0;
		if (cls >= NUM_CLASSES)
			return v;
		cur = reserved_q[cls[1:0]];
		lim = limit_q[cls[1:0]];
		sum = {1'b0, cur} + {1'b0, rate};
		case (cmd)
			CMD_CHECK: begin
				v.accepted = (sum <= {1'b0, lim});
			end
			CMD_RESERVE: begin
				cur = sum[RATE_W] ? '1 : sum[RATE_W-1:0];
				reserved_q[cls[1:0]] = cur;
				v.accepted = 1'b1;
			end
			CMD_RELEASE: begin
				cur = (cur >= rate) ? cur - rate : '0;
				reserved_q[cls[1:0]] = cur;
				v.accepted = 1'b1;
			end
			CMD_QUERY: begin
				if (lim == '0) begin
					v.percent = PCT_MAX;
				end else begin
					scaled = (64'(cur) * 64'(PCT_SCALE)) / 64'(lim);
					v.percent = (scaled > 64'(PCT_MAX)) ? PCT_MAX : scaled[PCT_W-1:0];
				end
				v.accepted = 1'b1;
			end
			CMD_CLEAR: begin
				foreach (reserved_q[i])
					reserved_q[i] = '0;
				cur = '0;
				v.accepted = 1'b1;
			end
			default: begin
				// unused code: counter reported, nothing applied
			end
		endcase
		v.usage = cur;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q[0] = LIMIT_RST_RT;
			limit_q[1] = LIMIT_RST_ST;
			limit_q[2] = LIMIT_RST_CT;
			limit_q[3] = LIMIT_RST_BE;
			foreach (reserved_q[i])
				reserved_q[i] = '0;
			expected_verdicts.delete();
			mismatches = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			// results first: a result never belongs to an item taken at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got.accepted = m_axis_tdata[0];
				got.percent  = m_axis_tdata[1 +: PCT_W];
				got.usage    = m_axis_tdata[USAGE_LSB +: RATE_W];
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result transaction: accepted %0b percent %0d usage %0d",
							got.accepted, got.percent, got.usage);
				end else begin
					want = expected_verdicts.pop_front();
					if (got.accepted !== want.accepted || got.percent !== want.percent ||
						got.usage !== want.usage) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("result mismatch (accepted/percent/usage): expected %0b/%0d/%0d, got %0b/%0d/%0d",
								want.accepted, want.percent, want.usage,
								got.accepted, got.percent, got.usage);
					end
				end
			end
			if (cfg_valid && cfg_ready)
				limit_q[cfg_index] = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				expected_verdicts.push_back(admit(s_axis_tdata[2:0],
					s_axis_tdata[CLS_LSB +: 3], s_axis_tdata[RATE_LSB +: RATE_W]));
			errors <= mismatches;
			pending <= expected_verdicts.size();
		end
	end

endmodule

// ----- dv/per_class_bandwidth_admission_core_test.sv -----
`timescale 1ns / 100ps

// stimulus and verdict for the admission core; the checker beside the dut
// watches all three channels and does the prediction and comparison
module per_class_bandwidth_admission_core_test;
	import pcba_pkg::*;

	localparam int HALF_PERIOD     = 6;
	localparam int RESET_CYCLES    = 9;
	localparam int GAP_MAX         = 16;
	localparam int ITEMS_PER_PHASE = 270;
	// margin that covers any straggler, including a query in the divider
	localparam int SETTLE_CYCLES   = 20;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int NUM_PLANS       = 5;

	// highest codes the 3-bit fields can carry
	localparam logic [2:0] CMD_TOP   = 3'h7;
	localparam logic [2:0] CLASS_TOP = 3'h7;

	// limit register indexes
	localparam logic [1:0] REG_LIMIT_RT = 2'd0;
	localparam logic [1:0] REG_LIMIT_ST = 2'd1;
	localparam logic [1:0] REG_LIMIT_CT = 2'd2;
	localparam logic [1:0] REG_LIMIT_BE = 2'd3;

	// limit settings walked through by the random part
	typedef enum int {
		LIM_FULL_SCALE,  // every limit at the counter maximum
		LIM_UNIT,        // every limit at one, queries saturate once usage reaches three
		LIM_NARROW,      // small limits, percent often saturates
		LIM_WIDE,        // random odd 32-bit limits
		LIM_MIXED        // by class: maximum, one, reset value, random
	} limit_plan_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// [2:0] command, [5:3] traffic_class, [37:6] flow_rate
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// [0] accepted, [8:1] usage_percent, [40:9] class_usage
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [1:0]             cfg_index;
	logic [RATE_W-1:0]      cfg_data;

	int          errors;
	int          pending;
	int          cycles = 0;
	int          items_sent = 0;
	int          off_class_items = 0;
	int          unused_code_items = 0;
	int          limit_writes = 0;
	int          ready_gap;
	bit          calm = 1'b0;  // when set, neither side idles
	limit_plan_t plan;

	per_class_bandwidth_admission_core dut (.*);

	admission_checker u_checker (.*);

	// clock
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// one input transaction, preceded by a random idle gap; tvalid stays high
	// into the next item when that item draws no gap
	task automatic send_command(input logic [2:0] cmd, input logic [2:0] cls,
		input logic [RATE_W-1:0] rate);
		int gap;
		gap = calm ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'({rate, cls, cmd});
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (cls >= NUM_CLASSES)
			off_class_items++;
		if (cmd > CMD_CLEAR)
			unused_code_items++;
	endtask

	// one limit write; only called while the core is idle
	task automatic write_limit(input logic [1:0] idx, input logic [RATE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		limit_writes++;
	endtask

	// stop sending and wait for every outstanding result, then let the core settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		// pending is a registered copy of the checker's result queue size
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [RATE_W-1:0] pick_limit(input limit_plan_t p, input int cls);
		case (p)
			LIM_FULL_SCALE: return '1;
			LIM_UNIT:       return RATE_W'(1);
			LIM_NARROW:     return RATE_W'($urandom_range(1, 1 << 16));
			LIM_WIDE:       return $urandom() | RATE_W'(1);
			default: begin
				if (cls == 0)
					return '1;
				if (cls == 1)
					return RATE_W'(1);
				if (cls == 2)
					return LIMIT_RST_CT;
				return $urandom();
			end
		endcase
	endfunction

	// log-spread rates plus the two extremes
	function automatic logic [RATE_W-1:0] draw_rate();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return $urandom();
			default: return $urandom() >> $urandom_range(1, 31);
		endcase
	endfunction

	// reserve and release keep the counters moving, clear stays rare
	function automatic logic [2:0] draw_command();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return CMD_RESERVE;
		if (pick < 45)
			return CMD_RELEASE;
		if (pick < 68)
			return CMD_CHECK;
		if (pick < 90)
			return CMD_QUERY;
		if (pick < 93)
			return CMD_CLEAR;
		return 3'($urandom_range(int'(CMD_CLEAR) + 1, int'(CMD_TOP)));
	endfunction

	function automatic logic [2:0] draw_class();
		if ($urandom_range(0, 99) < 85)
			return 3'($urandom_range(0, NUM_CLASSES - 1));
		return 3'($urandom_range(NUM_CLASSES, int'(CLASS_TOP)));
	endfunction

	// result side: random stall before each result, none while calm
	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			ready_gap = calm ? 0 : $urandom_range(0, GAP_MAX);
			if (ready_gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (ready_gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// stimulus
	initial begin
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the reset limits
		send_command(CMD_QUERY, 3'd0, '0);                  // empty class reads 0 percent
		send_command(CMD_CHECK, 3'd0, 32'd400000000);       // exactly at the limit fits
		send_command(CMD_CHECK, 3'd0, 32'd400000001);       // one over is refused
		send_command(CMD_RESERVE, 3'd0, 32'd100000000);
		send_command(CMD_CHECK, 3'd0, 32'd300000000);       // usage plus rate at the limit
		send_command(CMD_CHECK, 3'd0, 32'd300000001);
		send_command(CMD_CHECK, 3'd0, '1);                  // sum would wrap in 32 bits
		send_command(CMD_QUERY, 3'd0, '0);                  // 25 percent
		send_command(CMD_RESERVE, 3'd1, '1);                // counter at its maximum
		send_command(CMD_RESERVE, 3'd1, 32'd1);             // reserve saturates
		send_command(CMD_QUERY, 3'd1, '0);                  // percent saturates
		send_command(CMD_RELEASE, 3'd2, 32'd5);             // release clamps at zero
		send_command(CMD_RESERVE, 3'd3, '0);                // zero rate
		send_command(CMD_RESERVE, 3'd3, 32'd12345);
		send_command(CMD_RELEASE, 3'd3, '1);                // large release clamps
		send_command(CMD_RESERVE, 3'd4, 32'd777);           // invalid class ignored
		send_command(CMD_CHECK, 3'd7, '0);                  // invalid class refuses check
		send_command(3'(int'(CMD_CLEAR) + 1), 3'd1, '0);    // unused code reports counter
		send_command(CMD_TOP, 3'd0, '1);
		send_command(CMD_CLEAR, 3'd2, '0);                  // clear zeroes every class
		send_command(CMD_QUERY, 3'd1, '0);
		send_command(CMD_RESERVE, 3'd0, 32'd50);
		send_command(CMD_CLEAR, CLASS_TOP - 3'd1, '0);      // clear on invalid class does nothing
		drain();

		// zero limit: query reports full saturation
		write_limit(REG_LIMIT_BE, '0);
		send_command(CMD_RESERVE, 3'd3, 32'd1000);
		send_command(CMD_QUERY, 3'd3, '0);
		drain();

		// random part, one phase per limit plan
		for (int p = 0; p < NUM_PLANS; p++) begin
			plan = limit_plan_t'(p);
			for (int c = 0; c < NUM_CLASSES; c++)
				write_limit(2'(c), pick_limit(plan, c));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// stretches without idling on either side now and then
				if (n % 64 == 0)
					calm = ($urandom_range(0, 3) == 0);
				send_command(draw_command(), draw_class(), draw_rate());
			end
			calm = 1'b0;
			drain();
		end

		// back to the reset limits through the port, short run on them
		write_limit(REG_LIMIT_RT, LIMIT_RST_RT);
		write_limit(REG_LIMIT_ST, LIMIT_RST_ST);
		write_limit(REG_LIMIT_CT, LIMIT_RST_CT);
		write_limit(REG_LIMIT_BE, LIMIT_RST_BE);
		repeat (40)
			send_command(draw_command(), draw_class(), draw_rate());
		drain();

		$display("ran %0d commands, %0d on classes 4 to 7 and %0d with unused codes",
			items_sent, off_class_items, unused_code_items);
		$display("%0d limit writes over %0d limit settings, zero and full-scale limits included",
			limit_writes, NUM_PLANS + 2);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
